@@ design/ccd_pkg.sv @@
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and constants of the chunk cache directory: tag layout, slot
// entry layout, coordinate split and the scan tracker control group.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int SLOTS_DEFAULT = 256;
  localparam int COORD_BITS    = 16;
  localparam int CHUNK_SIDE    = 64;
  localparam int LAST_SIDE     = 4;
  localparam int CHUNK_SHIFT   = $clog2(CHUNK_SIDE);
  localparam int LAST_SHIFT    = $clog2(LAST_SIDE);
  localparam int TAG_ABC_W     = COORD_BITS - CHUNK_SHIFT;
  localparam int TAG_D_W       = COORD_BITS - LAST_SHIFT;
  localparam int OFFSET_W      = 3 * CHUNK_SHIFT + LAST_SHIFT;
  localparam int STAMP_W       = 64;
  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 80;

  localparam logic [STAMP_W-1:0] STAMP_START = STAMP_W'(1);

  typedef struct packed {
    logic [TAG_D_W-1:0]   d;
    logic [TAG_ABC_W-1:0] c;
    logic [TAG_ABC_W-1:0] b;
    logic [TAG_ABC_W-1:0] a;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic               dirty;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } track_ctl_t;

  function automatic tag_t chunk_tag(input logic [COORD_BITS-1:0] ca,
                                     input logic [COORD_BITS-1:0] cb,
                                     input logic [COORD_BITS-1:0] cc,
                                     input logic [COORD_BITS-1:0] cd);
    tag_t t;
    t.a = ca[COORD_BITS-1:CHUNK_SHIFT];
    t.b = cb[COORD_BITS-1:CHUNK_SHIFT];
    t.c = cc[COORD_BITS-1:CHUNK_SHIFT];
    t.d = cd[COORD_BITS-1:LAST_SHIFT];
    return t;
  endfunction

  // Power-of-two sides: the offset is the remainders laid side by side
  function automatic logic [OFFSET_W-1:0] chunk_offset(input logic [COORD_BITS-1:0] ca,
                                                       input logic [COORD_BITS-1:0] cb,
                                                       input logic [COORD_BITS-1:0] cc,
                                                       input logic [COORD_BITS-1:0] cd);
    return {ca[CHUNK_SHIFT-1:0], cb[CHUNK_SHIFT-1:0], cc[CHUNK_SHIFT-1:0],
            cd[LAST_SHIFT-1:0]};
  endfunction

endpackage

@@ design/ccd_ram.sv @@
// ----------------------------------------------------------------------------
// ccd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/ccd_track.sv @@
// ----------------------------------------------------------------------------
// ccd_track
// Scan tracker: watches the entries streamed out of the directory RAM and
// keeps the first tag match and the least-stamp victim (ties to lowest).
// ----------------------------------------------------------------------------
module ccd_track #(
  parameter int SLOTS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ccd_pkg::track_ctl_t      ctl,
  input  ccd_pkg::tag_t            key,
  input  ccd_pkg::entry_t          entry,
  input  logic [$clog2(SLOTS)-1:0] idx,
  output logic                     found,
  output logic [$clog2(SLOTS)-1:0] match_idx,
  output logic                     match_dirty,
  output logic [$clog2(SLOTS)-1:0] victim_idx,
  output ccd_pkg::tag_t            victim_tag,
  output logic                     victim_dirty
);
  import ccd_pkg::*;

  logic               have_min;
  logic [STAMP_W-1:0] min_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      have_min <= 1'b0;
    end else if (ctl.clear) begin
      found    <= 1'b0;
      have_min <= 1'b0;
    end else if (ctl.sample) begin
      if (!found && entry.tag == key) begin
        found       <= 1'b1;
        match_idx   <= idx;
        match_dirty <= entry.dirty;
      end
      // strict compare keeps the lowest index on equal stamps
      if (!have_min || entry.stamp < min_stamp) begin
        have_min     <= 1'b1;
        min_stamp    <= entry.stamp;
        victim_idx   <= idx;
        victim_tag   <= entry.tag;
        victim_dirty <= entry.dirty;
      end
    end
  end

  a_clear_sample_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.clear && ctl.sample))
    else $error("tracker cleared and sampled in one cycle");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> !found && !have_min)
    else $error("tracker not emptied by clear");

  a_found_needs_min: assert property (@(posedge clk) disable iff (rst)
    found |-> have_min)
    else $error("match recorded without any sampled entry");

endmodule

@@ design/chunk_cache_directory_lru.sv @@
// ----------------------------------------------------------------------------
// chunk_cache_directory_lru
// Directory of a fully associative chunk cache with LRU replacement and
// write-back flagging. Slot entries (tag, dirty, stamp) live in one RAM.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: coord_a..coord_d; tuser: operation
// m_*      out  m_tvalid/m_tready  tdata: hit, slot, element_offset,
//                                  writeback_needed, old_tag_a..old_tag_d
//
// Repeat of the last slot: checked with one read of that slot, no scan.
// Any other access scans every filled slot through the single RAM read port.
// Reset clears the fill count, so no clearing pass is needed.
// One item is worked at a time; the result register frees s_tready once the
// item is done, and the next result waits only if m_tready stays low.
// ----------------------------------------------------------------------------
module chunk_cache_directory_lru #(
  parameter int SLOTS = ccd_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // coord_a [15:0], coord_b [31:16], coord_c [47:32], coord_d [63:48]
  input  logic [ccd_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation [0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // hit [0], slot [8:1], element_offset [28:9], writeback_needed [29],
  // old_tag_a [39:30], old_tag_b [49:40], old_tag_c [59:50],
  // old_tag_d [73:60], zero [79:74]
  output logic [ccd_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ccd_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FILL_W = SLOT_W + 1;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SLOTS);

  typedef enum logic [2:0] {
    IDLE,
    RPT_CHK,
    SCAN,
    DECIDE,
    FINISH
  } state_t;

  state_t state;

  logic [FILL_W-1:0]  fill;
  logic [STAMP_W-1:0] use_counter;
  logic [SLOT_W-1:0]  last_slot;
  logic               last_valid;

  tag_t               key_tag;
  logic [OFFSET_W-1:0] key_offset;
  op_t                key_op;

  logic [FILL_W-1:0]  rd_idx;
  logic               pend;
  logic [SLOT_W-1:0]  pend_idx;

  logic               res_hit;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_wb;
  tag_t               res_old;

  logic               accept;
  logic               issue;
  logic               rpt_match;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  entry_t             rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  entry_t             wr_entry;
  track_ctl_t         tctl;
  tag_t               in_tag;

  logic               found;
  logic [SLOT_W-1:0]  match_idx;
  logic               match_dirty;
  logic [SLOT_W-1:0]  victim_idx;
  tag_t               victim_tag;
  logic               victim_dirty;

  assign s_tready  = (state == IDLE);
  assign accept    = s_tvalid && s_tready;
  assign issue     = (state == SCAN) && (rd_idx < fill);
  assign rd_entry  = entry_t'(rd_data);
  assign rpt_match = (rd_entry.tag == key_tag);
  assign in_tag    = chunk_tag(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                               s_tdata[63:48]);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = last_slot;
    if (state == IDLE) begin
      rd_en = accept && last_valid;
    end else if (issue) begin
      rd_en   = 1'b1;
      rd_addr = rd_idx[SLOT_W-1:0];
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = last_slot;
    wr_entry = rd_entry;
    unique case (state)
      RPT_CHK: begin
        // repeat hit keeps its stamp, only the dirty bit may rise
        wr_en          = rpt_match;
        wr_entry.dirty = rd_entry.dirty || (key_op == OP_WRITE);
      end
      DECIDE: begin
        wr_en          = 1'b1;
        wr_entry.tag   = key_tag;
        wr_entry.stamp = use_counter;
        wr_entry.dirty = (key_op == OP_WRITE);
        if (found) begin
          wr_addr        = match_idx;
          wr_entry.dirty = match_dirty || (key_op == OP_WRITE);
        end else if (fill < FILL_FULL) begin
          wr_addr = fill[SLOT_W-1:0];
        end else begin
          wr_addr = victim_idx;
        end
      end
      IDLE, SCAN, FINISH: begin
      end
      default: begin
      end
    endcase
  end

  assign tctl.clear  = (accept && !last_valid) || (state == RPT_CHK && !rpt_match);
  assign tctl.sample = pend && (state == SCAN);

  ccd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_dir_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_entry)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ccd_track #(
    .SLOTS (SLOTS)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .ctl          (tctl),
    .key          (key_tag),
    .entry        (rd_entry),
    .idx          (pend_idx),
    .found        (found),
    .match_idx    (match_idx),
    .match_dirty  (match_dirty),
    .victim_idx   (victim_idx),
    .victim_tag   (victim_tag),
    .victim_dirty (victim_dirty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      fill        <= '0;
      use_counter <= STAMP_START;
      last_slot   <= '0;
      last_valid  <= 1'b0;
      pend        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      pend     <= issue;
      pend_idx <= rd_idx[SLOT_W-1:0];
      // raise on a finished item, drop once the held beat is taken
      if (state == FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            key_tag    <= in_tag;
            key_offset <= chunk_offset(s_tdata[15:0], s_tdata[31:16],
                                       s_tdata[47:32], s_tdata[63:48]);
            key_op     <= op_t'(s_tuser);
            rd_idx     <= '0;
            state      <= last_valid ? RPT_CHK : SCAN;
          end
        end
        RPT_CHK: begin
          if (rpt_match) begin
            res_hit  <= 1'b1;
            res_slot <= last_slot;
            res_wb   <= 1'b0;
            res_old  <= '0;
            state    <= FINISH;
          end else begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + FILL_W'(1);
          end else if (!pend) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          use_counter <= use_counter + STAMP_W'(1);
          last_valid  <= 1'b1;
          last_slot   <= wr_addr;
          res_slot    <= wr_addr;
          res_hit     <= found;
          res_wb      <= 1'b0;
          res_old     <= '0;
          if (!found) begin
            if (fill < FILL_FULL) begin
              fill <= fill + FILL_W'(1);
            end else if (victim_dirty) begin
              res_wb  <= 1'b1;
              res_old <= victim_tag;
            end
          end
          state <= FINISH;
        end
        FINISH: begin
          // hold until the result register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {6'b0, res_old.d, res_old.c, res_old.b, res_old.a, res_wb,
                         key_offset, 8'(res_slot), res_hit};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count beyond slot count");

  a_last_filled: assert property (@(posedge clk) disable iff (rst)
    last_valid |-> ({1'b0, last_slot} < fill))
    else $error("last slot points past the filled slots");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("read and write of one slot in the same cycle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second beat taken while an access is in work");

endmodule
